>>> rtl/core/alist_pkg.sv
// Shared types, codes and defaults for the array list engine.
package alist_pkg;

  localparam int unsigned CapacityDefault = 16;
  localparam int unsigned WordBitsDefault = 32;

  localparam logic [2:0] CmdAppend = 3'd0;
  localparam logic [2:0] CmdSet    = 3'd1;
  localparam logic [2:0] CmdPop    = 3'd2;
  localparam logic [2:0] CmdDelete = 3'd3;
  localparam logic [2:0] CmdFind   = 3'd4;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StRange    = 3'd1;
  localparam logic [2:0] StEmpty    = 3'd2;
  localparam logic [2:0] StNotFound = 3'd3;
  localparam logic [2:0] StFull     = 3'd4;

  localparam logic [1:0] RdZero  = 2'd0;
  localparam logic [1:0] RdCur   = 2'd1;
  localparam logic [1:0] RdNext  = 2'd2;
  localparam logic [1:0] RdNext2 = 2'd3;

  localparam logic [1:0] WrAppend = 2'd0;
  localparam logic [1:0] WrSet    = 2'd1;
  localparam logic [1:0] WrShift  = 2'd2;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] value;
    logic [3:0]         position;
  } alist_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] found_index;
    logic [4:0] count;
    logic       empty_res;
  } alist_out_t;

  typedef struct packed {
    logic       load;
    logic [1:0] rd_sel;
    logic       idx_inc;
    logic       wr_en;
    logic [1:0] wr_sel;
    logic       fill_inc;
    logic       fill_dec;
    logic       res_load;
    logic [2:0] res_status;
    logic       res_found;
  } alist_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       fill_zero;
    logic       full;
    logic       pos_ok;
    logic       hit;
    logic       more;
  } alist_stat_t;

endpackage

>>> rtl/core/array_list_engine.sv
// Top level of the array list engine: controller and datapath.
// The engine keeps an ordered list of up to CAPACITY signed words and runs one
// command at a time. Append, set, pop and unused codes register their result
// in the execute state that follows acceptance of the word, once the output
// register is free. Find and delete scan the list one entry per cycle through
// the store's single registered read port, and delete then moves each later
// word down one place per cycle. The engine takes the next word in the cycle
// after a result is registered, while that result may still wait in the
// output register.
module array_list_engine #(
  parameter int unsigned CAPACITY  = alist_pkg::CapacityDefault,
  parameter int unsigned WORD_BITS = alist_pkg::WordBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  alist_pkg::alist_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output alist_pkg::alist_out_t out_data_o
);

  alist_pkg::alist_cmd_t  cmd;
  alist_pkg::alist_stat_t stat;

  alist_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  alist_dp #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule

>>> rtl/core/alist_dp.sv
// Datapath of the array list engine: word store, fill count, index and result register.
module alist_dp #(
  parameter int unsigned CAPACITY  = alist_pkg::CapacityDefault,
  parameter int unsigned WORD_BITS = alist_pkg::WordBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  alist_pkg::alist_in_t   in_data_i,
  input  alist_pkg::alist_cmd_t  cmd_i,
  output alist_pkg::alist_stat_t stat_o,
  output alist_pkg::alist_out_t  out_data_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = ((AW > CW) ? AW : CW) + 1;
  localparam int unsigned PW = CW + 4;
  localparam int unsigned RW = CW + 5;
  localparam int unsigned FW = AW + 4;

  logic [WORD_BITS-1:0] mem [CAPACITY];
  logic [WORD_BITS-1:0] rd_data_q;
  logic [WORD_BITS-1:0] word_q;
  logic [2:0]           cmd_q;
  logic [3:0]           pos_q;
  logic [AW-1:0]        idx_q;
  logic [CW-1:0]        fill_q, fill_d;
  alist_pkg::alist_out_t res_q;

  logic [XW-1:0]        idx_p1;
  logic [XW-1:0]        rd_sum;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic [RW-1:0]        cnt_ext;
  logic [FW-1:0]        idx_ext;

  assign idx_p1 = XW'(idx_q) + XW'(1);

  always_comb begin
    case (cmd_i.rd_sel)
      alist_pkg::RdZero:  rd_sum = '0;
      alist_pkg::RdCur:   rd_sum = XW'(idx_q);
      alist_pkg::RdNext:  rd_sum = idx_p1;
      alist_pkg::RdNext2: rd_sum = idx_p1 + XW'(1);
      default:            rd_sum = '0;
    endcase
  end

  assign rd_addr = (rd_sum < XW'(CAPACITY)) ? rd_sum[AW-1:0] : '0;

  always_comb begin
    case (cmd_i.wr_sel)
      alist_pkg::WrAppend: begin
        wr_addr = AW'(fill_q);
        wr_data = word_q;
      end
      alist_pkg::WrSet: begin
        wr_addr = AW'(pos_q);
        wr_data = word_q;
      end
      alist_pkg::WrShift: begin
        wr_addr = idx_q;
        wr_data = rd_data_q;
      end
      default: begin
        wr_addr = idx_q;
        wr_data = word_q;
      end
    endcase
  end

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.fill_inc) begin
      fill_d = fill_q + CW'(1);
    end else if (cmd_i.fill_dec) begin
      fill_d = fill_q - CW'(1);
    end
  end

  assign cnt_ext = RW'(fill_d);
  assign idx_ext = FW'(idx_q);

  assign stat_o.cmd       = cmd_q;
  assign stat_o.fill_zero = (fill_q == '0);
  assign stat_o.full      = (fill_q == CW'(CAPACITY));
  assign stat_o.pos_ok    = (PW'(pos_q) < PW'(fill_q));
  assign stat_o.hit       = (rd_data_q == word_q);
  assign stat_o.more      = (idx_p1 < XW'(fill_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q  <= in_data_i.cmd;
      word_q <= WORD_BITS'(in_data_i.value);
      pos_q  <= in_data_i.position;
      idx_q  <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + AW'(1);
    end
    if (cmd_i.res_load) begin
      res_q.status      <= cmd_i.res_status;
      res_q.found_index <= cmd_i.res_found ? idx_ext[3:0] : 4'd0;
      res_q.count       <= cnt_ext[4:0];
      res_q.empty_res   <= (fill_d == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  assign out_data_o = res_q;

endmodule

>>> rtl/core/alist_ctrl.sv
// Controller state machine of the array list engine.
module alist_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  alist_pkg::alist_stat_t stat_i,
  output alist_pkg::alist_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StExec,
    StSearch,
    StShift
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   done;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    done    = 1'b0;
    case (state_q)
      StIdle: begin
        cmd_o.rd_sel = alist_pkg::RdZero;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StExec;
        end
      end
      StExec: begin
        cmd_o.rd_sel = alist_pkg::RdZero;
        case (stat_i.cmd)
          alist_pkg::CmdAppend: begin
            done             = 1'b1;
            cmd_o.res_status = stat_i.full ? alist_pkg::StFull : alist_pkg::StOk;
            cmd_o.wr_en      = !stat_i.full;
            cmd_o.wr_sel     = alist_pkg::WrAppend;
            cmd_o.fill_inc   = !stat_i.full;
          end
          alist_pkg::CmdSet: begin
            done             = 1'b1;
            cmd_o.res_status = stat_i.pos_ok ? alist_pkg::StOk : alist_pkg::StRange;
            cmd_o.wr_en      = stat_i.pos_ok;
            cmd_o.wr_sel     = alist_pkg::WrSet;
          end
          alist_pkg::CmdPop: begin
            done             = 1'b1;
            cmd_o.res_status = stat_i.fill_zero ? alist_pkg::StEmpty : alist_pkg::StOk;
            cmd_o.fill_dec   = !stat_i.fill_zero;
          end
          alist_pkg::CmdDelete, alist_pkg::CmdFind: begin
            if (stat_i.fill_zero) begin
              done             = 1'b1;
              cmd_o.res_status = alist_pkg::StNotFound;
            end else begin
              state_d = StSearch;
            end
          end
          default: begin
            done             = 1'b1;
            cmd_o.res_status = alist_pkg::StOk;
          end
        endcase
      end
      StSearch: begin
        if (stat_i.hit) begin
          if (stat_i.cmd == alist_pkg::CmdDelete) begin
            cmd_o.rd_sel = alist_pkg::RdNext;
            state_d      = StShift;
          end else begin
            done             = 1'b1;
            cmd_o.res_status = alist_pkg::StOk;
            cmd_o.res_found  = 1'b1;
          end
        end else if (stat_i.more) begin
          cmd_o.idx_inc = 1'b1;
          cmd_o.rd_sel  = alist_pkg::RdNext;
        end else begin
          done             = 1'b1;
          cmd_o.res_status = alist_pkg::StNotFound;
        end
      end
      StShift: begin
        if (stat_i.more) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_sel  = alist_pkg::WrShift;
          cmd_o.idx_inc = 1'b1;
          cmd_o.rd_sel  = alist_pkg::RdNext2;
        end else begin
          done             = 1'b1;
          cmd_o.res_status = alist_pkg::StOk;
          cmd_o.fill_dec   = 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (done) begin
      if (out_free) begin
        cmd_o.res_load = 1'b1;
        state_d        = StIdle;
      end else begin
        cmd_o        = '0;
        cmd_o.rd_sel = alist_pkg::RdCur;
        state_d      = state_q;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/core/alist_checker.sv
// Port-level checks of the array list engine and their binding to the top level.
module alist_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input alist_pkg::alist_in_t  in_data_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input alist_pkg::alist_out_t out_data_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("Input word changed or dropped while stalled.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("Result word changed or dropped while stalled.");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("Engine took a second word while one was in work.");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.empty_res == (out_data_o.count == 5'd0)))
    else $error("Empty flag disagrees with the count.");

  a_found_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != alist_pkg::StOk) |-> out_data_o.found_index == 4'd0)
    else $error("Index reported on a failed command.");

endmodule

bind array_list_engine alist_checker u_alist_checker (.*);
